// ===== rtl/tpd_pkg.sv =====
// ----------------------------------------------------------------------------
// tpd_pkg: shared constants and types for the tilt PD motor drive
// Word formats, register indexes, reset values and the CORDIC arctan table.
// ----------------------------------------------------------------------------
package tpd_pkg;

	// default build parameters
	localparam int CORDIC_STEPS_DEF    = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 14;

	// field widths
	localparam int SMP_W     = 16;
	localparam int GAIN_W    = 24;
	localparam int PER_W     = 16;
	localparam int CFG_IDX_W = 2;

	// CORDIC datapath: x/y carry raw counts scaled by 2^PRE_SHIFT,
	// z carries radians in units of 2^-Z_FRAC
	localparam int ATAN_LEN  = 24;
	localparam int PRE_SHIFT = 20;
	localparam int Z_FRAC    = 30;
	localparam int XY_W      = 39;
	localparam int Z_W       = 33;

	// floor(q/100) for q < 2^Q_W as (q * DIV100_MUL) >> DIV100_SHIFT, exact
	localparam int              Q_W          = 23;
	localparam int              DIV100_W     = 24;
	localparam logic [DIV100_W-1:0] DIV100_MUL = 24'd10737419;
	localparam int              DIV100_SHIFT = 30;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = 2'd2;

	// register reset values
	localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 24'sd6553600;
	localparam logic signed [GAIN_W-1:0] RATE_GAIN_RST  = -24'sd6554;
	localparam logic [PER_W-1:0]         PWM_PERIOD_RST = 16'd3999;

	// atan(2^-i) * 2^30, truncated
	localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
		32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
		32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
		32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
	};

	typedef logic signed [SMP_W-1:0] sample_t;
	typedef logic [PER_W-1:0]        duty_t;

	// one result word
	typedef struct packed {
		logic  drive_dir;
		duty_t duty;
		logic  clamped;
	} drive_word_t;

endpackage

// ===== rtl/tpd_if.sv =====
// ----------------------------------------------------------------------------
// tpd_if: valid/ready channels of the tilt PD motor drive
// Sample channel (gyro rate, two accel axes) and drive result channel.
// ----------------------------------------------------------------------------
interface tpd_sample_if;
	import tpd_pkg::*;

	logic    valid;
	logic    ready;
	sample_t gyro_rate;
	sample_t accel_a;
	sample_t accel_b;

	modport source (output valid, gyro_rate, accel_a, accel_b, input ready);
	modport sink   (input valid, gyro_rate, accel_a, accel_b, output ready);
endinterface

interface tpd_drive_if;
	import tpd_pkg::*;

	logic  valid;
	logic  ready;
	logic  drive_dir;
	duty_t duty;
	logic  clamped;

	modport source (output valid, drive_dir, duty, clamped, input ready);
	modport sink   (input valid, drive_dir, duty, clamped, output ready);
endinterface

// ===== rtl/tilt_pd_motor_drive.sv =====
// ----------------------------------------------------------------------------
// tilt_pd_motor_drive: tilt angle PD controller with PWM duty output
// Throughput: one sample per cycle while the output buffer is not full; one CORDIC
// step per CORDIC stage, with the multiplies in s4, s7 and s8.
// A two-word output buffer keeps the pipeline moving while a result waits.
// Reset clears all valid bits and loads the gain and period register defaults.
// ----------------------------------------------------------------------------
module tilt_pd_motor_drive #(
	parameter int CORDIC_STEPS    = tpd_pkg::CORDIC_STEPS_DEF,
	parameter int ANGLE_FRAC_BITS = tpd_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	tpd_sample_if.sink                     sample,
	tpd_drive_if.source                    drive,
	input  logic                           cfg_we,
	input  logic [tpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tpd_pkg::GAIN_W-1:0]     cfg_wdata
);
	import tpd_pkg::*;

	// stage positions in the valid vector
	localparam int NST   = CORDIC_STEPS + 7;
	localparam int P_LST = NST - 1;

	// datapath widths
	localparam int ANG_W   = ANGLE_FRAC_BITS + 3;
	localparam int RND_SH  = Z_FRAC - ANGLE_FRAC_BITS;
	localparam int PP_W    = GAIN_W + ANG_W;
	localparam int PR_W    = GAIN_W + SMP_W;
	localparam int DR_W    = PR_W + ANGLE_FRAC_BITS + 1;
	localparam int DUTY_SH = 16 + ANGLE_FRAC_BITS;
	localparam int MAG_W   = 23 + ANGLE_FRAC_BITS;
	localparam int PRD_W   = MAG_W + PER_W;
	localparam int QM_W    = Q_W + DIV100_W;

	localparam logic signed [Z_W-1:0]  RND_ADD   = Z_W'(1) << (RND_SH - 1);
	localparam logic signed [DR_W-1:0] LIMIT     = DR_W'(100) << DUTY_SH;
	localparam logic signed [DR_W-1:0] NEG_LIMIT = -LIMIT;
	localparam logic [MAG_W-1:0]       LIMIT_MAG = LIMIT[MAG_W-1:0];
	localparam logic [1:0]             SKID_FULL = 2'd2;

	// configuration registers
	logic signed [GAIN_W-1:0] prop_gain_q;
	logic signed [GAIN_W-1:0] rate_gain_q;
	logic [PER_W-1:0]         pwm_period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= PROP_GAIN_RST;
			rate_gain_q  <= RATE_GAIN_RST;
			pwm_period_q <= PWM_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROP_GAIN:  prop_gain_q  <= cfg_wdata;
				REG_RATE_GAIN:  rate_gain_q  <= cfg_wdata;
				REG_PWM_PERIOD: pwm_period_q <= cfg_wdata[PER_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline advance: stalls only when the output buffer is full
	logic            en;
	logic [1:0]      cnt_q;
	logic [NST-1:0]  vld_q;

	assign en           = (cnt_q != SKID_FULL);
	assign sample.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], sample.valid};
		end
	end

	// s1: CORDIC start, x = |b|, y = a, both scaled
	logic signed [SMP_W:0]   b_ext;
	logic signed [SMP_W:0]   b_abs;
	logic signed [XY_W-1:0]  x_s1;
	logic signed [XY_W-1:0]  y_s1;
	sample_t                 rate_s1;
	logic                    zero_s1;

	always_comb begin
		b_ext = {sample.accel_b[SMP_W-1], sample.accel_b};
		b_abs = b_ext[SMP_W] ? -b_ext : b_ext;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= {{(XY_W-SMP_W-1-PRE_SHIFT){b_abs[SMP_W]}}, b_abs,
				{PRE_SHIFT{1'b0}}};
			y_s1    <= {{(XY_W-SMP_W-PRE_SHIFT){sample.accel_a[SMP_W-1]}},
				sample.accel_a, {PRE_SHIFT{1'b0}}};
			rate_s1 <= sample.gyro_rate;
			zero_s1 <= (sample.accel_a == '0) && (sample.accel_b == '0);
		end
	end

	// s2: one vectoring step per stage
	logic signed [XY_W-1:0] cx_s2    [CORDIC_STEPS];
	logic signed [XY_W-1:0] cy_s2    [CORDIC_STEPS];
	logic signed [Z_W-1:0]  cz_s2    [CORDIC_STEPS];
	sample_t                crate_s2 [CORDIC_STEPS];
	logic                   czero_s2 [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		logic signed [XY_W-1:0] xi;
		logic signed [XY_W-1:0] yi;
		logic signed [Z_W-1:0]  zi;
		sample_t                ri;
		logic                   fi;
		logic signed [XY_W-1:0] xs;
		logic signed [XY_W-1:0] ys;
		logic signed [Z_W-1:0]  at;

		if (i == 0) begin : g_first
			assign xi = x_s1;
			assign yi = y_s1;
			assign zi = '0;
			assign ri = rate_s1;
			assign fi = zero_s1;
		end else begin : g_next
			assign xi = cx_s2[i-1];
			assign yi = cy_s2[i-1];
			assign zi = cz_s2[i-1];
			assign ri = crate_s2[i-1];
			assign fi = czero_s2[i-1];
		end

		assign xs = xi >>> i;
		assign ys = yi >>> i;
		assign at = $signed({1'b0, ATAN_TAB[i]});

		always_ff @(posedge clk) begin
			if (en) begin
				if (!yi[XY_W-1]) begin
					cx_s2[i] <= xi + ys;
					cy_s2[i] <= yi - xs;
					cz_s2[i] <= zi + at;
				end else begin
					cx_s2[i] <= xi - ys;
					cy_s2[i] <= yi + xs;
					cz_s2[i] <= zi - at;
				end
				crate_s2[i] <= ri;
				czero_s2[i] <= fi;
			end
		end
	end

	// s3: round angle to ANGLE_FRAC_BITS, half up
	logic signed [Z_W-1:0]   z_rnd;
	logic signed [Z_W-1:0]   z_sh;
	logic signed [ANG_W-1:0] angle_s3;
	sample_t                 rate_s3;
	logic                    zero_s3;

	assign z_rnd = cz_s2[CORDIC_STEPS-1] + RND_ADD;
	assign z_sh  = z_rnd >>> RND_SH;

	always_ff @(posedge clk) begin
		if (en) begin
			angle_s3 <= z_sh[ANG_W-1:0];
			rate_s3  <= crate_s2[CORDIC_STEPS-1];
			zero_s3  <= czero_s2[CORDIC_STEPS-1];
		end
	end

	// s4: gain products
	logic signed [PP_W-1:0] pp_s4;
	logic signed [PR_W-1:0] pr_s4;
	logic                   zero_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s4   <= prop_gain_q * angle_s3;
			pr_s4   <= rate_gain_q * rate_s3;
			zero_s4 <= zero_s3;
		end
	end

	// s5: drive sum at 2^-(16+ANGLE_FRAC_BITS) percent
	logic signed [DR_W-1:0] drive_s5;
	logic                   zero_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			drive_s5 <= {{(DR_W-PP_W){pp_s4[PP_W-1]}}, pp_s4}
				+ {pr_s4[PR_W-1], pr_s4, {ANGLE_FRAC_BITS{1'b0}}};
			zero_s5  <= zero_s4;
		end
	end

	// s6: saturate to +-100, split into direction and magnitude
	logic signed [DR_W-1:0] drive_neg;
	logic [MAG_W-1:0]       mag_c;
	logic                   dir_c;
	logic                   clamp_c;
	logic [MAG_W-1:0]       mag_s6;
	logic                   dir_s6;
	logic                   clamp_s6;

	assign drive_neg = -drive_s5;

	always_comb begin
		priority if (zero_s5) begin
			mag_c   = '0;
			dir_c   = 1'b0;
			clamp_c = 1'b0;
		end else if (drive_s5 > LIMIT) begin
			mag_c   = LIMIT_MAG;
			dir_c   = 1'b1;
			clamp_c = 1'b1;
		end else if (drive_s5 < NEG_LIMIT) begin
			mag_c   = LIMIT_MAG;
			dir_c   = 1'b0;
			clamp_c = 1'b1;
		end else begin
			mag_c   = drive_s5[DR_W-1] ? drive_neg[MAG_W-1:0] : drive_s5[MAG_W-1:0];
			dir_c   = !drive_s5[DR_W-1] && (drive_s5 != '0);
			clamp_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s6   <= mag_c;
			dir_s6   <= dir_c;
			clamp_s6 <= clamp_c;
		end
	end

	// s7: magnitude times period
	logic [PRD_W-1:0] prd_s7;
	logic             dir_s7;
	logic             clamp_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			prd_s7   <= mag_s6 * pwm_period_q;
			dir_s7   <= dir_s6;
			clamp_s7 <= clamp_s6;
		end
	end

	// s8: drop the fixed-point scale, then divide by 100 via reciprocal
	logic [QM_W-1:0] qm_s8;
	logic            dir_s8;
	logic            clamp_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			qm_s8    <= prd_s7[DUTY_SH +: Q_W] * DIV100_MUL;
			dir_s8   <= dir_s7;
			clamp_s8 <= clamp_s7;
		end
	end

	// output buffer, two words deep
	drive_word_t new_word;
	drive_word_t sk0_q;
	drive_word_t sk1_q;
	logic        push;
	logic        pop;

	assign new_word.drive_dir = dir_s8;
	assign new_word.duty      = qm_s8[DIV100_SHIFT +: PER_W];
	assign new_word.clamped   = clamp_s8;

	assign push = en && vld_q[P_LST];
	assign pop  = drive.valid && drive.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case ({push, pop})
			2'b10: begin
				if (cnt_q == '0) begin
					sk0_q <= new_word;
				end else begin
					sk1_q <= new_word;
				end
			end
			2'b01:   sk0_q <= sk1_q;
			2'b11:   sk0_q <= new_word;
			default: ;
		endcase
	end

	assign drive.valid     = (cnt_q != '0);
	assign drive.drive_dir = sk0_q.drive_dir;
	assign drive.duty      = sk0_q.duty;
	assign drive.clamped   = sk0_q.clamped;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the tilt PD motor drive
// A directed table (extremes, both-axes-zero, drive exactly at the limits,
// period corners, spare register) is followed by random samples under several
// gain settings. Each result word is checked against a hand-typed word or a bit-true software
// CORDIC/PD model held in the bench, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
	import tpd_pkg::*;

	localparam int  ANG_FRAC     = ANGLE_FRAC_BITS_DEF;
	localparam int  N_STEPS      = CORDIC_STEPS_DEF;
	localparam int  PIPE_LAT     = N_STEPS + 7;
	localparam int  CYCLE_LIMIT  = 300000;
	localparam int  SEG_ITEMS    = 170;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef enum logic {ROW_CFG, ROW_SMP} row_kind_t;

	// one line of the directed table
	typedef struct {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [GAIN_W-1:0]    data;
		sample_t              g;
		sample_t              a;
		sample_t              b;
		bit                   typed;
		drive_word_t          word;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [GAIN_W-1:0]    cfg_wdata;

	tpd_sample_if smp ();
	tpd_drive_if  drv ();

	tilt_pd_motor_drive uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (smp),
		.drive     (drv),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// bench copy of the registers
	longint prop_gain_sh;
	longint rate_gain_sh;
	longint period_sh;

	drive_word_t pending_drive_q[$];
	stim_row_t   stim_rows[$];

	int src_idle;
	int snk_idle;
	int cycles;
	int n_items;
	int n_directed;
	int n_writes;
	int n_results;
	int n_clamped;
	int n_errors;

	always #6 clk = ~clk;

	// atan(2^-i) in units of 2^-30 rad, truncated
	function automatic longint atan_q30(input int i);
		case (i)
			0:  return 64'h3243F6A8;
			1:  return 64'h1DAC6705;
			2:  return 64'h0FADBAFC;
			3:  return 64'h07F56EA6;
			4:  return 64'h03FEAB76;
			5:  return 64'h01FFD55B;
			6:  return 64'h00FFFAAA;
			7:  return 64'h007FFF55;
			8:  return 64'h003FFFEA;
			9:  return 64'h001FFFFD;
			10: return 64'h000FFFFF;
			11: return 64'h0007FFFF;
			12: return 64'h0003FFFF;
			13: return 64'h0001FFFF;
			14: return 64'h0000FFFF;
			15: return 64'h00007FFF;
			16: return 64'h00003FFF;
			17: return 64'h00001FFF;
			18: return 64'h00000FFF;
			19: return 64'h000007FF;
			20: return 64'h000003FF;
			21: return 64'h000001FF;
			22: return 64'h000000FF;
			default: return 64'h0000007F;
		endcase
	endfunction

	// expected drive word for one sample under the current register copy
	function automatic drive_word_t tilt_drive_calc(input sample_t g, input sample_t a,
			input sample_t b);
		longint x, y, z, xs, ys, ang, drv_val, lim, mag, duty;
		bit clamp;
		drive_word_t w;
		w = '{drive_dir: 1'b0, duty: '0, clamped: 1'b0};
		if (a == 0 && b == 0)
			return w;
		// vectoring CORDIC on (|b|, a)
		x = longint'(b);
		if (x < 0)
			x = -x;
		x = x * 64'sd1048576;
		y = longint'(a) * 64'sd1048576;
		z = 0;
		for (int i = 0; i < N_STEPS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + atan_q30(i);
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - atan_q30(i);
			end
		end
		// round to ANG_FRAC fraction bits, half up
		ang = (z + (64'sd1 <<< (30 - ANG_FRAC - 1))) >>> (30 - ANG_FRAC);
		// PD sum at 2^-(16+ANG_FRAC) percent, then saturate
		drv_val = prop_gain_sh * ang + rate_gain_sh * longint'(g) * (64'sd1 <<< ANG_FRAC);
		lim = 64'sd100 * (64'sd1 <<< (16 + ANG_FRAC));
		clamp = 1'b0;
		if (drv_val > lim) begin
			drv_val = lim;
			clamp = 1'b1;
		end else if (drv_val < -lim) begin
			drv_val = -lim;
			clamp = 1'b1;
		end
		mag = (drv_val < 0) ? -drv_val : drv_val;
		duty = (mag * period_sh) / lim;
		w.drive_dir = (drv_val > 0);
		w.duty = duty[15:0];
		w.clamped = clamp;
		return w;
	endfunction

	function automatic void reg_shadow_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [GAIN_W-1:0] data);
		case (idx)
			REG_PROP_GAIN:  prop_gain_sh = longint'($signed(data));
			REG_RATE_GAIN:  rate_gain_sh = longint'($signed(data));
			REG_PWM_PERIOD: period_sh = longint'({48'd0, data[15:0]});
			default: ;
		endcase
	endfunction

	// directed table builders
	function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [GAIN_W-1:0] data);
		stim_row_t r;
		r = '{kind: ROW_CFG, idx: idx, data: data, g: '0, a: '0, b: '0, typed: 1'b0,
			word: '0};
		stim_rows.push_back(r);
	endfunction

	function automatic void add_smp(input int g, input int a, input int b);
		stim_row_t r;
		r = '{kind: ROW_SMP, idx: '0, data: '0, g: sample_t'(g), a: sample_t'(a),
			b: sample_t'(b), typed: 1'b0, word: '0};
		stim_rows.push_back(r);
	endfunction

	function automatic void add_chk(input int g, input int a, input int b,
			input logic dir, input int duty, input logic clamp);
		stim_row_t r;
		r = '{kind: ROW_SMP, idx: '0, data: '0, g: sample_t'(g), a: sample_t'(a),
			b: sample_t'(b), typed: 1'b1,
			word: '{drive_dir: dir, duty: duty_t'(duty), clamped: clamp}};
		stim_rows.push_back(r);
	endfunction

	// present one sample word, hold until accepted, log its expected result
	task automatic send_sample(input sample_t g, input sample_t a, input sample_t b,
			input bit typed, input drive_word_t typed_word);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle) begin
			smp.valid <= 1'b0;
			@(negedge clk);
		end
		smp.valid     <= 1'b1;
		smp.gyro_rate <= g;
		smp.accel_a   <= a;
		smp.accel_b   <= b;
		do
			@(posedge clk);
		while (!smp.ready);
		pending_drive_q.push_back(typed ? typed_word : tilt_drive_calc(g, a, b));
		n_items++;
	endtask

	// register write once the pipe has drained
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
		@(negedge clk);
		smp.valid <= 1'b0;
		while (pending_drive_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		reg_shadow_write(idx, data);
		n_writes++;
	endtask

	function automatic sample_t rand_accel();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			2, 3, 4: return sample_t'(int'($urandom_range(0, 400)) - 200);
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic sample_t rand_gyro();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return sample_t'(int'($urandom_range(0, 800)) - 400);
			6, 7, 8:          return sample_t'($urandom);
			default:          return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		endcase
	endfunction

	// compare one accepted drive word with its expected value
	task automatic check_word(input drive_word_t want);
		bit bad;
		bad = (drv.drive_dir !== want.drive_dir) || (drv.duty !== want.duty) ||
			(drv.clamped !== want.clamped);
		n_results++;
		if (want.clamped)
			n_clamped++;
		if (bad) begin
			n_errors++;
			if (drv.drive_dir !== want.drive_dir)
				$display("%0t: drive_dir expected %0b actual %0b", $time,
					want.drive_dir, drv.drive_dir);
			if (drv.duty !== want.duty)
				$display("%0t: duty expected %0d actual %0d", $time,
					want.duty, drv.duty);
			if (drv.clamped !== want.clamped)
				$display("%0t: clamped expected %0b actual %0b", $time,
					want.clamped, drv.clamped);
		end
	endtask

	// receiver: random stalls
	always @(negedge clk) begin
		if (!arst_n)
			drv.ready <= 1'b0;
		else
			drv.ready <= ($urandom_range(0, 99) >= snk_idle);
	end

	// result checker and cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still expected", $time,
				pending_drive_q.size());
			$display("Regression FAIL");
			$finish;
		end else if (arst_n && drv.valid && drv.ready) begin
			if (pending_drive_q.size() == 0) begin
				n_errors++;
				$display("%0t: expected no word, actual dir=%0b duty=%0d clamped=%0b",
					$time, drv.drive_dir, drv.duty, drv.clamped);
			end else begin
				check_word(pending_drive_q.pop_front());
			end
		end
	end

	initial begin
		stim_row_t row;
		logic [GAIN_W-1:0] pg, rg, per;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		smp.valid = 1'b0;
		smp.gyro_rate = '0;
		smp.accel_a = '0;
		smp.accel_b = '0;
		cycles = 0;
		n_items = 0;
		n_writes = 0;
		n_results = 0;
		n_clamped = 0;
		n_errors = 0;
		src_idle = 34;
		snk_idle = 52;
		prop_gain_sh = longint'(PROP_GAIN_RST);
		rate_gain_sh = longint'(RATE_GAIN_RST);
		period_sh = longint'({48'd0, PWM_PERIOD_RST});

		// directed table, reset gains first
		add_chk(0, 0, 0, 1'b0, 0, 1'b0);
		add_chk(32767, 0, 0, 1'b0, 0, 1'b0);
		add_chk(-32768, 32767, 0, 1'b1, 3999, 1'b1);
		add_chk(32767, -32768, 0, 1'b0, 3999, 1'b1);
		add_smp(0, 0, -32768);
		add_smp(0, 0, 32767);
		add_smp(0, 16384, 16384);
		add_smp(0, -100, -100);
		add_smp(-32768, -32768, -32768);
		add_smp(32767, 32767, 32767);
		add_smp(100, 1, 0);
		add_smp(-1, -1, 1);
		// rate path only, gain of exactly 100 per count: hit the limit exactly
		add_cfg(REG_PROP_GAIN, 24'd0);
		add_cfg(REG_RATE_GAIN, 24'd6553600);
		add_chk(1, 5, 7, 1'b1, 3999, 1'b0);
		add_chk(-1, 5, 7, 1'b0, 3999, 1'b0);
		add_chk(0, 5, 7, 1'b0, 0, 1'b0);
		add_chk(2, 5, 7, 1'b1, 3999, 1'b1);
		add_chk(-32768, 5, 7, 1'b0, 3999, 1'b1);
		add_cfg(REG_PWM_PERIOD, 24'h00FFFF);
		add_chk(1, 1, 1, 1'b1, 65535, 1'b0);
		add_chk(-2, 1, 1, 1'b0, 65535, 1'b1);
		add_cfg(REG_PWM_PERIOD, 24'h000001);
		add_chk(-1, 1, 1, 1'b0, 1, 1'b0);
		// period zero, upper data bits ignored
		add_cfg(REG_PWM_PERIOD, 24'hAB0000);
		add_chk(1, 1, 1, 1'b1, 0, 1'b0);
		add_chk(-3, 1, 1, 1'b0, 0, 1'b1);
		// spare index must not touch anything
		add_cfg(REG_SPARE, 24'hFFFFFF);
		add_chk(1, 1, 1, 1'b1, 0, 1'b0);
		add_cfg(REG_PROP_GAIN, PROP_GAIN_RST);
		add_cfg(REG_RATE_GAIN, RATE_GAIN_RST);
		add_cfg(REG_PWM_PERIOD, {8'd0, PWM_PERIOD_RST});
		add_smp(200, -3000, 9000);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (stim_rows[i]) begin
			row = stim_rows[i];
			if (row.kind == ROW_CFG)
				write_reg(row.idx, row.data);
			else
				send_sample(row.g, row.a, row.b, row.typed, row.word);
		end
		n_directed = n_items;

		// random part: six gain settings, idling pattern changes every two
		for (int seg = 0; seg < 6; seg++) begin
			case (seg)
				0: begin
					pg = PROP_GAIN_RST;
					rg = RATE_GAIN_RST;
					per = {8'd0, PWM_PERIOD_RST};
				end
				1: begin
					pg = 24'h7FFFFF;
					rg = 24'h800000;
					per = {8'($urandom), 16'hFFFF};
				end
				2: begin
					pg = 24'h800000;
					rg = 24'h7FFFFF;
					per = 24'd1;
				end
				3: begin
					pg = GAIN_W'(int'($urandom_range(0, 120 * 65536)) - 60 * 65536);
					rg = GAIN_W'(int'($urandom_range(0, 8192)) - 4096);
					per = {8'd0, 16'($urandom_range(1, 65535))};
				end
				4: begin
					pg = GAIN_W'($urandom);
					rg = GAIN_W'($urandom);
					per = GAIN_W'($urandom);
				end
				default: begin
					pg = GAIN_W'(int'($urandom_range(0, 240 * 65536)) - 120 * 65536);
					rg = GAIN_W'(int'($urandom_range(0, 32768)) - 16384);
					per = {8'd0, PWM_PERIOD_RST};
				end
			endcase
			src_idle = (seg < 2) ? 34 : (seg < 4) ? 52 : 0;
			snk_idle = (seg < 2) ? 52 : (seg < 4) ? 34 : 0;
			write_reg(REG_PROP_GAIN, pg);
			write_reg(REG_RATE_GAIN, rg);
			write_reg(REG_PWM_PERIOD, per);
			if (seg == 5)
				write_reg(REG_SPARE, GAIN_W'($urandom));
			for (int k = 0; k < SEG_ITEMS; k++) begin
				if ($urandom_range(0, 99) < 3)
					send_sample(rand_gyro(), '0, '0, 1'b0, '0);
				else
					send_sample(rand_gyro(), rand_accel(), rand_accel(), 1'b0, '0);
			end
		end

		// drain and let the pipe run dry
		@(negedge clk);
		smp.valid <= 1'b0;
		while (pending_drive_q.size() != 0)
			@(posedge clk);
		repeat (2 * PIPE_LAT) @(posedge clk);

		$display("Sent %0d samples (%0d from the directed table) across %0d register writes.",
			n_items, n_directed, n_writes);
		$display("Checked %0d drive words, %0d of them saturated; %0d mismatches.",
			n_results, n_clamped, n_errors);
		if (n_errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
